// File: sv/vwf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and job types for the video window fit block
package vwf_pkg;

  // dimension widths
  localparam int unsigned DIM_BITS  = 13;
  localparam int unsigned PROD_BITS = 2 * DIM_BITS;
  localparam int unsigned CNT_BITS  = $clog2(DIM_BITS + 1);

  // geometry constants
  localparam int unsigned BORDER       = 1;
  localparam int unsigned PERCENT_BASE = 100;
  localparam logic [DIM_BITS-1:0] BORDER_D  = DIM_BITS'(BORDER);
  localparam logic [DIM_BITS-1:0] BORDER2_D = DIM_BITS'(2 * BORDER);
  localparam logic [DIM_BITS-1:0] PERCENT_D = DIM_BITS'(PERCENT_BASE);

  // percent divide by reciprocal multiply, exact for products below 2^PCT_NUM_BITS
  localparam int unsigned PCT_BASE_BITS  = $clog2(PERCENT_BASE);
  localparam int unsigned PCT_NUM_BITS   = DIM_BITS + PCT_BASE_BITS;
  localparam int unsigned PCT_SHIFT      = PCT_NUM_BITS + PCT_BASE_BITS;
  localparam int unsigned PCT_RECIP_BITS = PCT_SHIFT - PCT_BASE_BITS + 1;
  localparam int unsigned PCT_PROD_BITS  = PCT_NUM_BITS + PCT_RECIP_BITS;
  localparam longint unsigned PCT_RECIP  =
      ((64'd1 << PCT_SHIFT) + PERCENT_BASE - 1) / PERCENT_BASE;

  // fit mode codes
  localparam int unsigned MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_FULL         = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PERCENT      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ORIG         = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CUSTOM       = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_RATIO        = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_CUSTOM_RATIO = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARAM_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARAM_HEIGHT = 2'd2;

  // job queue between front and back
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // work for one dimension: either a direct value or a quotient num / den
  typedef struct packed {
    logic                 use_div;
    logic [PROD_BITS-1:0] num;
    logic [DIM_BITS-1:0]  den;
    logic [DIM_BITS-1:0]  val;
  } dim_job_t;

  typedef struct packed {
    logic                placed;
    logic [DIM_BITS-1:0] sw;
    logic [DIM_BITS-1:0] sh;
    dim_job_t            w;
    dim_job_t            h;
  } job_t;

endpackage

// File: sv/vwf_intf.sv
`timescale 1ns / 1ps
// Handshake channel interfaces for window items, placements and configuration
interface vwf_in_if;
  logic                          valid;
  logic                          ready;
  logic [vwf_pkg::DIM_BITS-1:0]  window_width;
  logic [vwf_pkg::DIM_BITS-1:0]  window_height;
  logic [vwf_pkg::DIM_BITS-1:0]  picture_width;
  logic [vwf_pkg::DIM_BITS-1:0]  picture_height;
  logic                          playing;

  modport source (output valid, window_width, window_height, picture_width,
                  picture_height, playing, input ready);
  modport sink   (input valid, window_width, window_height, picture_width,
                  picture_height, playing, output ready);
endinterface

interface vwf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          placed;
  logic [vwf_pkg::DIM_BITS-1:0]  rect_x;
  logic [vwf_pkg::DIM_BITS-1:0]  rect_y;
  logic [vwf_pkg::DIM_BITS-1:0]  rect_w;
  logic [vwf_pkg::DIM_BITS-1:0]  rect_h;

  modport source (output valid, placed, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, placed, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface vwf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vwf_pkg::CFG_IDX_BITS-1:0]  index;
  logic [vwf_pkg::DIM_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/vwf_front.sv
`timescale 1ns / 1ps
// Front end: config registers, screen and picture fallback, products, job build
module vwf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vwf_in_if.sink          in_i,
  vwf_cfg_if.sink         cfg_i,
  output logic            push_o,
  output vwf_pkg::job_t   job_o,
  input  logic            full_i
);

  localparam int unsigned D  = vwf_pkg::DIM_BITS;
  localparam int unsigned PW = vwf_pkg::PROD_BITS;
  localparam int unsigned PN = vwf_pkg::PCT_NUM_BITS;
  localparam int unsigned PS = vwf_pkg::PCT_SHIFT;
  localparam int unsigned PP = vwf_pkg::PCT_PROD_BITS;

  typedef enum logic [1:0] {
    C_EMPTY,
    C_DIRECT,
    C_PCT,
    C_RATIO
  } cls_e;

  // configuration registers
  logic [vwf_pkg::MODE_BITS-1:0] mode_q;
  logic [D-1:0]                  param_w_q;
  logic [D-1:0]                  param_h_q;

  // stage 1 registers
  logic         s1_valid_q;
  cls_e         cls1_q;
  logic [D-1:0] sw1_q, sh1_q, x0_1_q, y0_1_q, x1_1_q, y1_1_q;

  // stage 2 registers
  logic          s2_valid_q;
  cls_e          cls2_q;
  logic [D-1:0]  sw2_q, sh2_q, x0_2_q, x1_2_q;
  logic [PW-1:0] p0_q, p1_q, lim0_q, lim1_q;

  // stage 1 combinational values
  logic         in_xfer;
  logic         empty;
  logic [D-1:0] sw, sh, pwe, phe;
  cls_e         cls_d;
  logic [D-1:0] x0_d, y0_d, x1_d, y1_d;

  logic s2_adv;

  // percent quotients
  logic [PP-1:0] pct_w, pct_h;

  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= vwf_pkg::MODE_FULL;
      param_w_q <= vwf_pkg::PERCENT_D;
      param_h_q <= vwf_pkg::PERCENT_D;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vwf_pkg::CFG_FIT_MODE:     mode_q    <= cfg_i.data[vwf_pkg::MODE_BITS-1:0];
        vwf_pkg::CFG_PARAM_WIDTH:  param_w_q <= cfg_i.data;
        vwf_pkg::CFG_PARAM_HEIGHT: param_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign push_o     = s2_valid_q && !full_i;
  assign s2_adv     = !s2_valid_q || push_o;
  assign in_i.ready = !s1_valid_q || s2_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  // screen size and picture fallback
  always_comb begin
    empty = (in_i.window_width <= vwf_pkg::BORDER2_D) ||
            (in_i.window_height <= vwf_pkg::BORDER2_D);
    sw  = in_i.window_width - vwf_pkg::BORDER2_D;
    sh  = in_i.window_height - vwf_pkg::BORDER2_D;
    pwe = (in_i.playing && (in_i.picture_width != '0)) ? in_i.picture_width : sw;
    phe = (in_i.playing && (in_i.picture_height != '0)) ? in_i.picture_height : sh;
  end

  // mode classification and multiplier operands
  always_comb begin
    cls_d = C_DIRECT;
    x0_d  = '0;
    y0_d  = '0;
    x1_d  = '0;
    y1_d  = '0;
    case (mode_q)
      vwf_pkg::MODE_FULL: begin
        x0_d = sw;
        x1_d = sh;
      end
      vwf_pkg::MODE_PERCENT: begin
        cls_d = C_PCT;
        x0_d  = pwe;
        y0_d  = param_w_q;
        x1_d  = phe;
        y1_d  = param_h_q;
      end
      vwf_pkg::MODE_ORIG: begin
        x0_d = pwe;
        x1_d = phe;
      end
      vwf_pkg::MODE_CUSTOM: begin
        x0_d = param_w_q;
        x1_d = param_h_q;
      end
      vwf_pkg::MODE_RATIO: begin
        cls_d = C_RATIO;
        x0_d  = pwe;
        y0_d  = sh;
        x1_d  = phe;
        y1_d  = sw;
      end
      vwf_pkg::MODE_CUSTOM_RATIO: begin
        if ((param_w_q == '0) || (param_h_q == '0)) begin
          x0_d = sw;
          x1_d = sh;
        end else begin
          cls_d = C_RATIO;
          x0_d  = param_w_q;
          y0_d  = sh;
          x1_d  = param_h_q;
          y1_d  = sw;
        end
      end
      default: ;
    endcase
    if (empty) begin
      cls_d = C_EMPTY;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1 capture on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cls1_q <= cls_d;
      sw1_q  <= sw;
      sh1_q  <= sh;
      x0_1_q <= x0_d;
      y0_1_q <= y0_d;
      x1_1_q <= x1_d;
      y1_1_q <= y1_d;
    end
  end

  // stage 2: products and percent limits
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      cls2_q <= cls1_q;
      sw2_q  <= sw1_q;
      sh2_q  <= sh1_q;
      x0_2_q <= x0_1_q;
      x1_2_q <= x1_1_q;
      p0_q   <= PW'(x0_1_q) * PW'(y0_1_q);
      p1_q   <= PW'(x1_1_q) * PW'(y1_1_q);
      lim0_q <= PW'(sw1_q) * PW'(vwf_pkg::PERCENT_BASE);
      lim1_q <= PW'(sh1_q) * PW'(vwf_pkg::PERCENT_BASE);
    end
  end

  // divide by 100 as a reciprocal multiply; only used below the screen limit
  assign pct_w = PP'(p0_q[PN-1:0]) * PP'(vwf_pkg::PCT_RECIP);
  assign pct_h = PP'(p1_q[PN-1:0]) * PP'(vwf_pkg::PCT_RECIP);

  // job build: compares pick direct values or quotients
  always_comb begin
    job_o.placed    = (cls2_q != C_EMPTY);
    job_o.sw        = sw2_q;
    job_o.sh        = sh2_q;
    job_o.w.use_div = 1'b0;
    job_o.w.num     = p0_q;
    job_o.w.den     = x1_2_q;
    job_o.w.val     = x0_2_q;
    job_o.h.use_div = 1'b0;
    job_o.h.num     = p1_q;
    job_o.h.den     = x0_2_q;
    job_o.h.val     = x1_2_q;
    case (cls2_q)
      C_PCT: begin
        if (p0_q >= lim0_q) begin
          job_o.w.val = sw2_q;
        end else begin
          job_o.w.val = pct_w[PS +: D];
        end
        if (p1_q >= lim1_q) begin
          job_o.h.val = sh2_q;
        end else begin
          job_o.h.val = pct_h[PS +: D];
        end
      end
      C_RATIO: begin
        // wider than the screen: full width, height from the ratio
        if (p0_q > p1_q) begin
          job_o.w.val     = sw2_q;
          job_o.h.use_div = 1'b1;
        end else begin
          job_o.h.val     = sh2_q;
          job_o.w.use_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/vwf_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the back end
module vwf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vwf_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output vwf_pkg::job_t  job_o
);

  localparam int unsigned PB = vwf_pkg::FIFO_PTR_BITS;
  localparam int unsigned CB = vwf_pkg::FIFO_CNT_BITS;

  vwf_pkg::job_t mem_q [vwf_pkg::FIFO_DEPTH];
  logic [PB-1:0] wr_ptr_q, rd_ptr_q;
  logic [CB-1:0] cnt_q;

  assign full_o  = (cnt_q == CB'(vwf_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PB'(vwf_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PB'(vwf_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: sv/vwf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient known to fit DIM_BITS
module vwf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vwf_pkg::PROD_BITS-1:0] num_i,
  input  logic [vwf_pkg::DIM_BITS-1:0]  den_i,
  output logic                          busy_o,
  output logic [vwf_pkg::DIM_BITS-1:0]  quot_o
);

  localparam int unsigned D  = vwf_pkg::DIM_BITS;
  localparam int unsigned PW = vwf_pkg::PROD_BITS;
  localparam int unsigned CW = vwf_pkg::CNT_BITS;

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [D-1:0]  rem_q, low_q, den_q, quot_q;
  logic [D:0]    trial, diff;
  logic          ge;

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  // one trial subtraction
  assign trial = {rem_q, low_q[D-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(D);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[PW-1:D];
      low_q  <= num_i[D-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[D-1:0] : trial[D-1:0];
      low_q  <= {low_q[D-2:0], 1'b0};
      quot_q <= {quot_q[D-2:0], ge};
    end
  end

endmodule

// File: sv/vwf_back.sv
`timescale 1ns / 1ps
// Back end: runs the divides of a job, clamps, rounds, centres and holds the result
module vwf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  vwf_pkg::job_t  job_i,
  output logic           pop_o,
  vwf_out_if.source      out_o
);

  localparam int unsigned D  = vwf_pkg::DIM_BITS;
  localparam int unsigned PW = vwf_pkg::PROD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e        state_q, state_d;
  vwf_pkg::job_t job_q, job_d;
  logic [D-1:0]  w_q, w_d, h_q, h_d;
  logic          sel_q, sel_d;

  logic          out_valid_q;
  logic          placed_q;
  logic [D-1:0]  rect_x_q, rect_y_q, rect_w_q, rect_h_q;

  logic          div_start, div_busy;
  logic [PW-1:0] div_num;
  logic [D-1:0]  div_den, div_quot;

  logic          fin_go, launch;
  logic [D-1:0]  dw_cl, dh_cl, dw_r, dh_r, rx, ry;

  vwf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign fin_go = !out_valid_q || out_o.ready;
  assign launch = valid_i && ((state_q == ST_IDLE) || ((state_q == ST_FIN) && fin_go));
  assign pop_o  = launch;

  // sequencing of the divides
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    w_d       = w_q;
    h_d       = h_q;
    sel_d     = sel_q;
    div_start = 1'b0;
    div_num   = job_q.h.num;
    div_den   = job_q.h.den;
    case (state_q)
      ST_DIV: begin
        if (!div_busy) begin
          if (sel_q) begin
            h_d = div_quot;
          end else begin
            w_d = div_quot;
          end
          if (!sel_q && job_q.h.use_div) begin
            div_start = 1'b1;
            sel_d     = 1'b1;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: ;
    endcase
    // take the next job from the queue
    if (launch) begin
      job_d = job_i;
      w_d   = job_i.w.val;
      h_d   = job_i.h.val;
      if (job_i.w.use_div) begin
        div_start = 1'b1;
        div_num   = job_i.w.num;
        div_den   = job_i.w.den;
        sel_d     = 1'b0;
        state_d   = ST_DIV;
      end else if (job_i.h.use_div) begin
        div_start = 1'b1;
        div_num   = job_i.h.num;
        div_den   = job_i.h.den;
        sel_d     = 1'b1;
        state_d   = ST_DIV;
      end else begin
        state_d = ST_FIN;
      end
    end
  end

  // clamp to the screen, round down to four, centre inside the border
  always_comb begin
    dw_cl = (w_q > job_q.sw) ? job_q.sw : w_q;
    dh_cl = (h_q > job_q.sh) ? job_q.sh : h_q;
    dw_r  = {dw_cl[D-1:2], 2'b00};
    dh_r  = {dh_cl[D-1:2], 2'b00};
    rx    = vwf_pkg::BORDER_D + ((job_q.sw - dw_r) >> 1);
    ry    = vwf_pkg::BORDER_D + ((job_q.sh - dh_r) >> 1);
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      placed_q    <= 1'b0;
      rect_x_q    <= '0;
      rect_y_q    <= '0;
      rect_w_q    <= '0;
      rect_h_q    <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      if ((state_q == ST_FIN) && fin_go) begin
        out_valid_q <= 1'b1;
        placed_q    <= job_q.placed;
        rect_x_q    <= job_q.placed ? rx : '0;
        rect_y_q    <= job_q.placed ? ry : '0;
        rect_w_q    <= job_q.placed ? dw_r : '0;
        rect_h_q    <= job_q.placed ? dh_r : '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    w_q   <= w_d;
    h_q   <= h_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.placed = placed_q;
  assign out_o.rect_x = rect_x_q;
  assign out_o.rect_y = rect_y_q;
  assign out_o.rect_w = rect_w_q;
  assign out_o.rect_h = rect_h_q;

endmodule

// File: sv/video_window_fit.sv
`timescale 1ns / 1ps
// Top level of the video window fit block: front end, job queue, back end
//
//   channel  | dir | payload                                              | transfer
//   ---------+-----+------------------------------------------------------+------------
//   in_i     | in  | window_width/height, picture_width/height, playing   | valid&ready
//   cfg_i    | in  | index (0 fit_mode, 1 param_width, 2 param_height)    | valid&ready
//   out_o    | out | placed, rect_x, rect_y, rect_w, rect_h               | valid&ready
//
// A direct or percent size passes two front stages, the queue, the back end
// and the output register on its way to out_o. A ratio fit also runs the
// shared restoring divider in the back end, one quotient bit per cycle, and
// the back end takes no new job until it is done; all other modes take a new
// job as soon as the last result can leave. The front end keeps taking items
// while the back end divides, until the two-entry queue and both front stages
// are full. cfg_i is always ready. Reset is asynchronous, active low; fit_mode
// resets to full screen and both parameters to 100.
module video_window_fit (
  input  logic     clk_i,
  input  logic     rst_ni,
  vwf_in_if.sink   in_i,
  vwf_cfg_if.sink  cfg_i,
  vwf_out_if.source out_o
);

  logic          push, full, pop, q_valid;
  vwf_pkg::job_t push_job, head_job;

  vwf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  vwf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  vwf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: sv/vwf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the video window fit block and their bind
module vwf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         placed,
  input logic [vwf_pkg::DIM_BITS-1:0] rect_x,
  input logic [vwf_pkg::DIM_BITS-1:0] rect_y,
  input logic [vwf_pkg::DIM_BITS-1:0] rect_w,
  input logic [vwf_pkg::DIM_BITS-1:0] rect_h
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
      $stable({placed, rect_x, rect_y, rect_w, rect_h}))
    else $error("result changed while stalled");

  // placed rectangles are 4-aligned in size and inside the border
  a_placed_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && placed |-> (rect_w[1:0] == 2'b00) && (rect_h[1:0] == 2'b00) &&
      (rect_x != '0) && (rect_y != '0))
    else $error("placed rectangle misaligned or on the border");

  // no placement gives an all-zero rectangle
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !placed |-> (rect_x == '0) && (rect_y == '0) &&
      (rect_w == '0) && (rect_h == '0))
    else $error("empty screen result not zero");

  // nothing offered during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind video_window_fit vwf_checker u_vwf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .placed    (out_o.placed),
  .rect_x    (out_o.rect_x),
  .rect_y    (out_o.rect_y),
  .rect_w    (out_o.rect_w),
  .rect_h    (out_o.rect_h)
);
